// ----- src/event_timer_scheduler_macros.svh -----
// Assertion macros shared by the checkers of the event timer scheduler.
`ifndef EVENT_TIMER_SCHEDULER_MACROS_SVH
`define EVENT_TIMER_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ETS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ets_chk: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ETS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ets_chk: assertion failed");

`endif

// ----- src/ets_pkg.sv -----
`timescale 1ns / 1ps

package ets_pkg;

    localparam int NUM_EVENTS = 8;
    localparam int EVT_IDX_W  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int GUARD_W    = $clog2(NUM_EVENTS + 3);
    localparam int CYCLE_W    = 32;

    localparam logic [CYCLE_W-1:0] NO_DISTANCE = '1;

    // Request codes
    localparam logic [1:0] REQ_ADVANCE  = 2'd0;
    localparam logic [1:0] REQ_SCHEDULE = 2'd1;
    localparam logic [1:0] REQ_CANCEL   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         event_index;
        logic [CYCLE_W-1:0] due_cycle;
        logic [CYCLE_W-1:0] cycle_count;
    } t_req;

    typedef struct packed {
        logic               fired;
        logic [2:0]         fired_index;
        logic [CYCLE_W-1:0] now_cycle;
        logic               last;
    } t_rsp;

    // Event table write port
    typedef struct packed {
        logic                 we_act;
        logic                 act_val;
        logic                 we_due;
        logic [EVT_IDX_W-1:0] idx;
        logic [CYCLE_W-1:0]   due;
    } t_tbl_wr;

    // Event table read data
    typedef struct packed {
        logic               act;
        logic [CYCLE_W-1:0] due;
    } t_tbl_rd;

    // Shared adder / comparator operands and results
    typedef struct packed {
        logic [CYCLE_W-1:0] a;
        logic [CYCLE_W-1:0] b;
        logic [CYCLE_W-1:0] c;
        logic               sub;
    } t_alu_in;

    typedef struct packed {
        logic [CYCLE_W-1:0] res;
        logic               le;
        logic               lt;
        logic               zero;
    } t_alu_out;

endpackage

// ----- src/event_timer_scheduler.sv -----
`timescale 1ns / 1ps
// Event timer scheduler: a table of NUM_EVENTS timed events and a 32-bit cycle counter.
// Input channel (i_in_valid / o_in_stall / i_in_data): one request item at a time.
//   o_in_stall is high from the cycle after an item is accepted until its closing
//   result has been loaded into the output register.
// Output channel (o_out_valid / i_out_stall / o_out_data): a fired-event item per
//   entry that comes due (fired 1, last 0), then one closing item (fired 0, last 1)
//   that carries the new cycle count.
// Schedule and cancel with an in-range index load the closing item after a table scan:
//   one shared adder/comparator scans the table one entry per cycle for the nearest
//   due time. The next request can be taken in the cycle after the closing item is loaded.
// Advance checks the gap to the nearest due time; for each due time reached it runs
//   step, table scan, nearest-time update and gap check again, then adds what is left
//   of the count, and waits whenever an item meets a stalled output.
// Output register holds one item; while i_out_stall is high and it is full the scan
//   holds at the entry that wants to fire, and the item stays on o_out_data.
// Synchronous active-low reset clears the cycle count, sets the nearest due time to
//   all ones, clears every active bit and empties the output register.
module event_timer_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ets_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ets_pkg::t_rsp o_out_data
);
    import ets_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_NEAR  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_CLOSE = 3'd6;

    localparam logic [EVT_IDX_W-1:0] K_LAST    = EVT_IDX_W'(NUM_EVENTS - 1);
    localparam logic [GUARD_W-1:0]   GUARD_MAX = GUARD_W'(NUM_EVENTS + 2);

    logic [2:0]           r_state, n_state;
    logic [CYCLE_W-1:0]   r_cur, n_cur;
    logic [CYCLE_W-1:0]   r_near, n_near;
    logic [CYCLE_W-1:0]   r_rem, n_rem;
    logic [CYCLE_W-1:0]   r_gap, n_gap;
    logic [CYCLE_W-1:0]   r_best, n_best;
    logic [EVT_IDX_W-1:0] r_k, n_k;
    logic                 r_fire_mode, n_fire_mode;
    logic [GUARD_W-1:0]   r_guard, n_guard;
    logic                 r_out_valid;
    t_rsp                 r_out;

    t_alu_in  alu_in;
    t_alu_out alu_out;
    t_tbl_wr  tbl_wr;
    t_tbl_rd  tbl_rd;
    logic     out_ok;
    logic     out_load;
    t_rsp     out_next;
    logic     in_range;
    logic     hit;
    logic     step;

    ets_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    ets_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .i_rd_idx (r_k),
        .o_rd     (tbl_rd)
    );

    assign out_ok   = !r_out_valid || !i_out_stall;
    assign in_range = 32'(i_in_data.event_index) < 32'(NUM_EVENTS);
    assign hit      = r_fire_mode && tbl_rd.act && alu_out.zero;

    // Sequence one request through the shared adder and the table scan
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_near      = r_near;
        n_rem       = r_rem;
        n_gap       = r_gap;
        n_best      = r_best;
        n_k         = r_k;
        n_fire_mode = r_fire_mode;
        n_guard     = r_guard;
        alu_in.a    = r_cur;
        alu_in.b    = r_rem;
        alu_in.c    = r_rem;
        alu_in.sub  = 1'b0;
        tbl_wr      = '0;
        out_load    = 1'b0;
        out_next    = '0;
        step        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.req_type) inside
                        REQ_ADVANCE: begin
                            n_rem   = i_in_data.cycle_count;
                            n_guard = '0;
                            n_state = S_CHECK;
                        end
                        REQ_SCHEDULE, REQ_CANCEL: begin
                            if (in_range) begin
                                tbl_wr.we_act  = 1'b1;
                                tbl_wr.act_val = (i_in_data.req_type == REQ_SCHEDULE);
                                tbl_wr.we_due  = (i_in_data.req_type == REQ_SCHEDULE);
                                tbl_wr.idx     = EVT_IDX_W'(i_in_data.event_index);
                                tbl_wr.due     = i_in_data.due_cycle;
                                n_best         = NO_DISTANCE;
                                n_k            = '0;
                                n_fire_mode    = 1'b0;
                                n_state        = S_SCAN;
                            end else begin
                                n_state = S_CLOSE;
                            end
                        end
                        default: n_state = S_CLOSE;
                    endcase
                end
            end
            S_CHECK: begin
                // Gap to the nearest due time against the remaining count
                alu_in.a   = r_near;
                alu_in.b   = r_cur;
                alu_in.c   = r_rem;
                alu_in.sub = 1'b1;
                if (alu_out.le && (r_guard < GUARD_MAX)) begin
                    n_gap   = alu_out.res;
                    n_state = S_STEP;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_STEP: begin
                // Jump to the due time and consume the gap
                alu_in.a    = r_rem;
                alu_in.b    = r_gap;
                alu_in.sub  = 1'b1;
                n_rem       = alu_out.res;
                n_cur       = r_near;
                n_best      = NO_DISTANCE;
                n_k         = '0;
                n_fire_mode = 1'b1;
                n_guard     = r_guard + 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                // Fire entries due now, track the smallest distance of the rest
                alu_in.a   = tbl_rd.due;
                alu_in.b   = r_cur;
                alu_in.c   = r_best;
                alu_in.sub = 1'b1;
                if (hit) begin
                    if (out_ok) begin
                        out_load             = 1'b1;
                        out_next.fired       = 1'b1;
                        out_next.fired_index = 3'(r_k);
                        out_next.now_cycle   = r_cur;
                        out_next.last        = 1'b0;
                        tbl_wr.we_act        = 1'b1;
                        tbl_wr.act_val       = 1'b0;
                        tbl_wr.idx           = r_k;
                        step                 = 1'b1;
                    end
                end else begin
                    if (tbl_rd.act && alu_out.lt) begin
                        n_best = alu_out.res;
                    end
                    step = 1'b1;
                end
                if (step) begin
                    if (r_k == K_LAST) begin
                        n_state = S_NEAR;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_NEAR: begin
                alu_in.a = r_cur;
                alu_in.b = r_best;
                n_near   = alu_out.res;
                n_state  = r_fire_mode ? S_CHECK : S_CLOSE;
            end
            S_FINAL: begin
                // Add what is left of the count
                alu_in.a = r_cur;
                alu_in.b = r_rem;
                n_cur    = alu_out.res;
                n_state  = S_CLOSE;
            end
            S_CLOSE: begin
                if (out_ok) begin
                    out_load           = 1'b1;
                    out_next.fired     = 1'b0;
                    out_next.now_cycle = r_cur;
                    out_next.last      = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state and the timer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_near  <= NO_DISTANCE;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_near  <= n_near;
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_gap       <= n_gap;
        r_best      <= n_best;
        r_k         <= n_k;
        r_fire_mode <= n_fire_mode;
        r_guard     <= n_guard;
    end

    // Output register: load a new item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/ets_alu.sv -----
`timescale 1ns / 1ps

module ets_alu (
    input  ets_pkg::t_alu_in  i_op,
    output ets_pkg::t_alu_out o_res
);
    import ets_pkg::*;

    logic [CYCLE_W-1:0] res;

    // Add or subtract modulo 2^32, then compare against the third operand
    assign res        = i_op.sub ? (i_op.a - i_op.b) : (i_op.a + i_op.b);
    assign o_res.res  = res;
    assign o_res.le   = (res <= i_op.c);
    assign o_res.lt   = (res < i_op.c);
    assign o_res.zero = (res == '0);

endmodule

// ----- src/ets_table.sv -----
`timescale 1ns / 1ps

module ets_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ets_pkg::t_tbl_wr              i_wr,
    input  logic [ets_pkg::EVT_IDX_W-1:0] i_rd_idx,
    output ets_pkg::t_tbl_rd              o_rd
);
    import ets_pkg::*;

    logic [NUM_EVENTS-1:0] r_act;
    logic [CYCLE_W-1:0]    r_due [NUM_EVENTS];

    // Update active bits; reset clears every entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else if (i_wr.we_act) begin
            r_act[i_wr.idx] <= i_wr.act_val;
        end
    end

    // Store due cycles; only used while the entry is active
    always_ff @(posedge i_clk) begin
        if (i_wr.we_due) begin
            r_due[i_wr.idx] <= i_wr.due;
        end
    end

    // Read the entry under the scan pointer
    assign o_rd.act = r_act[i_rd_idx];
    assign o_rd.due = r_due[i_rd_idx];

endmodule

// ----- src/ets_chk.sv -----
`timescale 1ns / 1ps
`include "event_timer_scheduler_macros.svh"

module ets_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input ets_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ets_pkg::t_rsp o_out_data
);
    import ets_pkg::*;

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // Keep a stalled item valid and unchanged
    `ETS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ETS_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // Go busy after every accepted request
    `ETS_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall)

    // Fired items never close a request; the closing item reports no event
    `ETS_ASSERT_IMP(a_fired_not_last, i_clk, i_rst_n, o_out_valid, o_out_data.fired != o_out_data.last)
    `ETS_ASSERT_IMP(a_close_idx_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.fired, o_out_data.fired_index == 3'd0)

endmodule

bind event_timer_scheduler ets_chk u_ets_chk (.*);

// ----- dv/event_timer_checker.sv -----
`timescale 1ns / 1ps

module event_timer_checker
    import ets_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_req               i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_rsp               i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic [CYCLE_W-1:0] o_now_cycle
);

    // Shadow copy of the timer state
    logic [CYCLE_W-1:0] now_cyc;
    logic [CYCLE_W-1:0] next_due;
    logic               evt_armed [NUM_EVENTS];
    logic [CYCLE_W-1:0] evt_due   [NUM_EVENTS];

    // Results owed by accepted items, oldest first
    t_rsp timer_results_q [$];
    int   fails = 0;

    task automatic report(input string what, input logic [CYCLE_W-1:0] got,
                          input logic [CYCLE_W-1:0] want);
        $display("%0t ets mismatch: %s got %0h want %0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic owe_result(input logic fired, input logic [2:0] idx, input logic last);
        t_rsp r;
        r.fired       = fired;
        r.fired_index = idx;
        r.now_cycle   = now_cyc;
        r.last        = last;
        timer_results_q.push_back(r);
    endtask

    // Nearest due cycle: now plus the smallest wrapped distance over armed entries
    task automatic refresh_next_due();
        logic [CYCLE_W-1:0] best;
        logic [CYCLE_W-1:0] span;
        best = NO_DISTANCE;
        for (int k = 0; k < NUM_EVENTS; k++) begin
            if (evt_armed[k]) begin
                span = evt_due[k] - now_cyc;
                if (span < best)
                    best = span;
            end
        end
        next_due = now_cyc + best;
    endtask

    // Apply one request item and queue every result it causes
    task automatic step_timer(input t_req r);
        logic [CYCLE_W-1:0] left;
        logic [CYCLE_W-1:0] gap;
        int                 passes;
        bit                 stop;
        case (r.req_type) inside
            REQ_SCHEDULE, REQ_CANCEL: begin
                if (int'(r.event_index) < NUM_EVENTS) begin
                    evt_armed[r.event_index] = (r.req_type == REQ_SCHEDULE);
                    if (r.req_type == REQ_SCHEDULE)
                        evt_due[r.event_index] = r.due_cycle;
                    refresh_next_due();
                end
            end
            REQ_ADVANCE: begin
                left   = r.cycle_count;
                passes = 0;
                stop   = 1'b0;
                // step to each due time in reach, fire what is due there
                while (!stop && passes < NUM_EVENTS + 2) begin
                    gap = next_due - now_cyc;
                    if (gap > left) begin
                        stop = 1'b1;
                    end else begin
                        left    = left - gap;
                        now_cyc = next_due;
                        for (int k = 0; k < NUM_EVENTS; k++) begin
                            if (evt_armed[k] && evt_due[k] == now_cyc) begin
                                evt_armed[k] = 1'b0;
                                owe_result(1'b1, 3'(k), 1'b0);
                            end
                        end
                        refresh_next_due();
                        passes++;
                    end
                end
                now_cyc = now_cyc + left;
            end
            default: begin
            end
        endcase
        owe_result(1'b0, 3'd0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            now_cyc  = '0;
            next_due = NO_DISTANCE;
            for (int k = 0; k < NUM_EVENTS; k++) begin
                evt_armed[k] = 1'b0;
                evt_due[k]   = '0;
            end
            timer_results_q.delete();
        end else begin
            // compare the outgoing item before queuing anything new this edge
            if (i_out_valid && !i_out_stall) begin
                if (timer_results_q.size() == 0) begin
                    report("item with nothing owed, now_cycle", i_out_data.now_cycle, '0);
                end else begin
                    want = timer_results_q.pop_front();
                    if (i_out_data.fired !== want.fired)
                        report("fired", i_out_data.fired, want.fired);
                    if (i_out_data.fired_index !== want.fired_index)
                        report("fired_index", i_out_data.fired_index, want.fired_index);
                    if (i_out_data.now_cycle !== want.now_cycle)
                        report("now_cycle", i_out_data.now_cycle, want.now_cycle);
                    if (i_out_data.last !== want.last)
                        report("last", i_out_data.last, want.last);
                end
            end
            if (i_in_valid && !i_in_stall)
                step_timer(i_in_data);
        end
        o_pending    <= timer_results_q.size();
        o_now_cycle  <= now_cyc;
        o_fail_count <= fails;
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ets_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 4 * (NUM_EVENTS + 3);

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_req               in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_rsp               out_data;
    int                 fail_count;
    int                 pending;
    logic [CYCLE_W-1:0] model_now;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic hold_ask   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    event_timer_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    event_timer_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_now_cycle  (model_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: one long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_ask && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // End the run when no item moves on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_req mk_req(input logic [1:0] rt, input logic [2:0] idx,
                                    input logic [CYCLE_W-1:0] due,
                                    input logic [CYCLE_W-1:0] cnt);
        t_req r;
        r.req_type    = rt;
        r.event_index = idx;
        r.due_cycle   = due;
        r.cycle_count = cnt;
        return r;
    endfunction

    // Offer one item after a random gap; return at the edge that takes it
    task automatic send(input t_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
    endtask

    // Wait until every owed result has come out
    task automatic settle();
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic send_settled(input t_req r);
        send(r);
        in_valid <= 1'b0;
        settle();
    endtask

    // Mostly schedule bursts near now followed by an advance; some noise
    task automatic run_phase(input int n_items, input int idle, input int stall);
        int                 sent;
        logic [1:0]         rt;
        logic [CYCLE_W-1:0] base;
        logic [CYCLE_W-1:0] cnt;
        idle_pct  = idle;
        stall_pct <= stall;
        sent      = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 20) begin
                rt = 2'($urandom_range(0, 3));
                send(mk_req(rt, 3'($urandom), $urandom, $urandom));
                if (rt != REQ_UNUSED)
                    sent++;
            end else begin
                // now and then move the clock close to the wrap point
                if ($urandom_range(0, 19) == 0) begin
                    send(mk_req(REQ_ADVANCE, 3'($urandom), $urandom,
                                32'(0) - model_now - 32'($urandom_range(0, 30))));
                    sent++;
                end
                base = model_now;
                repeat ($urandom_range(1, 4)) begin
                    send(mk_req(REQ_SCHEDULE, 3'($urandom),
                                base + 32'($urandom_range(0, 4) * 6), $urandom));
                    sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    send(mk_req(REQ_CANCEL, 3'($urandom), $urandom, $urandom));
                    sent++;
                end
                cnt = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
                send(mk_req(REQ_ADVANCE, 3'($urandom), $urandom, cnt));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: zero advance, then a full-range step through the empty slot
        send_settled(mk_req(REQ_ADVANCE, 3'd0, '0, '0));
        send_settled(mk_req(REQ_ADVANCE, 3'd7, NO_DISTANCE, NO_DISTANCE));

        // Event due now fires on a zero advance
        send_settled(mk_req(REQ_SCHEDULE, 3'd0, model_now, '0));
        send_settled(mk_req(REQ_ADVANCE, 3'd0, '0, '0));

        // Several due times across the wrap, a cancel, an idle cancel, unused code
        send_settled(mk_req(REQ_SCHEDULE, 3'd1, model_now + 32'd5, NO_DISTANCE));
        send_settled(mk_req(REQ_SCHEDULE, 3'd2, model_now + 32'd5, '0));
        send_settled(mk_req(REQ_SCHEDULE, 3'd7, model_now + 32'd2, '0));
        send_settled(mk_req(REQ_SCHEDULE, 3'd3, model_now + 32'd100, '0));
        send_settled(mk_req(REQ_CANCEL, 3'd3, '0, '0));
        send_settled(mk_req(REQ_CANCEL, 3'd5, NO_DISTANCE, NO_DISTANCE));
        send_settled(mk_req(REQ_UNUSED, 3'd7, NO_DISTANCE, NO_DISTANCE));
        send_settled(mk_req(REQ_ADVANCE, 3'd0, '0, 32'd10));

        // Every entry due at once: the longest burst of results
        for (int k = 0; k < NUM_EVENTS; k++)
            send_settled(mk_req(REQ_SCHEDULE, 3'(k), model_now + 32'd1, '0));
        send_settled(mk_req(REQ_ADVANCE, 3'd0, '0, NO_DISTANCE));

        // Farthest distance and extreme due values
        send_settled(mk_req(REQ_SCHEDULE, 3'd6, model_now - 32'd1, '0));
        send_settled(mk_req(REQ_SCHEDULE, 3'd4, NO_DISTANCE, '0));
        send_settled(mk_req(REQ_SCHEDULE, 3'd5, '0, '0));
        send_settled(mk_req(REQ_ADVANCE, 3'd0, '0, NO_DISTANCE));

        // Random part; the first phase starts with a long receiver hold-off
        hold_ask <= 1'b1;
        run_phase(75, 0, 0);
        run_phase(75, 80, 0);
        run_phase(75, 0, 80);
        run_phase(75, 31, 31);
        in_valid <= 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
